// File: design/tgp_pkg.sv
// ----------------------------------------------------------------------------
// tgp_pkg
// shared types and constants of the text glyph placer
// ----------------------------------------------------------------------------
package tgp_pkg;

    // input opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CHAR  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    // commands passed from front to back
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_GLYPH = 2'd1;
    localparam logic [1:0] CMD_ROW   = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // command queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [7:0]        w;
        logic [7:0]        h;
        logic signed [7:0] bx;
        logic [7:0]        ly;
        logic [7:0]        adv;
        logic [15:0]       ax;
        logic [7:0]        ay;
    } t_glyph;

    typedef struct packed {
        logic [7:0] code;
        logic [6:0] idx;
        t_glyph     glyph;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        t_glyph     glyph;
    } t_cmd;

    typedef struct packed {
        logic               kind;
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic [15:0]        span_width;
        logic [7:0]         span_height;
        logic [15:0]        src_x;
        logic [8:0]         src_y;
        logic               row_empty;
    } t_result;

endpackage

// File: design/tgp_front.sv
// ----------------------------------------------------------------------------
// tgp_front
// accepts items, keeps the glyph table, classifies characters
// ----------------------------------------------------------------------------
module tgp_front #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_opcode,
    input  tgp_pkg::t_item i_item,
    input  logic [7:0]    i_first_code,
    input  logic [8:0]    i_end_code,
    output logic          o_push,
    output tgp_pkg::t_cmd o_cmd,
    input  logic          i_q_full
);
    import tgp_pkg::*;

    localparam int         AW     = $clog2(TABLE_DEPTH);
    localparam logic [8:0] DEPTH9 = 9'(TABLE_DEPTH);

    t_glyph     r_mem [TABLE_DEPTH];
    t_glyph     r_rdata;
    logic       r_s1_valid;
    logic [1:0] r_kind;

    logic       accept;
    logic       n_push;
    logic [1:0] n_kind;
    logic       wr_en;
    logic       rd_en;
    logic [8:0] idx9;
    logic [8:0] code9;
    logic [7:0] off;
    logic [8:0] off9;
    logic       in_range;

    assign o_ready = !r_s1_valid || !i_q_full;
    assign accept  = i_valid && o_ready;

    assign idx9     = {2'b0, i_item.idx};
    assign code9    = {1'b0, i_item.code};
    assign off      = i_item.code - i_first_code;
    assign off9     = {1'b0, off};
    assign in_range = (code9 >= {1'b0, i_first_code}) && (code9 < i_end_code)
                      && (off9 < DEPTH9);

    always_comb begin
        n_push = 1'b0;
        n_kind = CMD_START;
        wr_en  = 1'b0;
        rd_en  = 1'b0;
        unique case (i_opcode)
            OP_LOAD: begin
                wr_en = idx9 < DEPTH9;
            end
            OP_CHAR: begin
                if (i_item.code == NEWLINE_CODE) begin
                    n_push = 1'b1;
                    n_kind = CMD_ROW;
                end else if (in_range) begin
                    n_push = 1'b1;
                    n_kind = CMD_GLYPH;
                    rd_en  = 1'b1;
                end
            end
            OP_START: begin
                n_push = 1'b1;
                n_kind = CMD_START;
            end
            OP_END: begin
                n_push = 1'b1;
                n_kind = CMD_ROW;
            end
            default: begin
                n_push = 1'b0;
            end
        endcase
    end

    // glyph table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_mem[idx9[AW-1:0]] <= i_item.glyph;
        end
        if (accept && rd_en) begin
            r_rdata <= r_mem[off9[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= accept && n_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= n_kind;
        end
    end

    assign o_push      = r_s1_valid && !i_q_full;
    assign o_cmd.kind  = r_kind;
    assign o_cmd.glyph = r_rdata;

endmodule

// File: design/tgp_queue.sv
// ----------------------------------------------------------------------------
// tgp_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module tgp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tgp_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tgp_pkg::t_cmd o_cmd
);
    import tgp_pkg::*;

    t_cmd          r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_full  = r_count == (Q_AW+1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/tgp_back.sv
// ----------------------------------------------------------------------------
// tgp_back
// pen cursor and row extent, glyph placement, clipping and result register
// ----------------------------------------------------------------------------
module tgp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  tgp_pkg::t_cmd       i_cmd,
    output logic                o_pop,
    input  logic signed [15:0]  i_origin_left,
    input  logic signed [15:0]  i_origin_top,
    input  logic [13:0]         i_frame_width,
    input  logic [13:0]         i_frame_height,
    input  logic [7:0]          i_line_height,
    output logic                o_valid,
    input  logic                i_ready,
    output tgp_pkg::t_result    o_result
);
    import tgp_pkg::*;

    typedef struct packed {
        logic               row;
        logic               empty;
        logic signed [18:0] x0;
        logic signed [17:0] y0;
        logic [15:0]        w;
        logic [7:0]         h;
        logic [15:0]        ax;
        logic [7:0]         ay;
    } t_stage;

    // cursor state
    logic [16:0]       r_pen_x;
    logic [15:0]       r_line_y;
    logic signed [7:0] r_row_min;
    logic [16:0]       r_row_max;
    logic [16:0]       n_pen_x;
    logic [15:0]       n_line_y;
    logic signed [7:0] n_row_min;
    logic [16:0]       n_row_max;

    logic   r_a_valid;
    t_stage r_a;
    t_stage n_a;
    logic   r_b_valid;
    t_result r_b;
    t_result n_b;

    logic a_adv;
    logic b_ready;

    // stage a arithmetic
    logic signed [18:0] rel;
    logic signed [18:0] row_min19;
    logic [17:0]        pen_adv;
    logic [16:0]        pen_sat;
    logic [18:0]        row_wd;
    logic [16:0]        line_sum;

    // stage b arithmetic
    logic signed [19:0] x0e, xs, xe, xc, fw20, dx, skip_x;
    logic signed [18:0] y0e, ys, ye, yc, fh19, dy, skip_y;
    logic signed [16:0] org17, fw17;
    logic               emit;

    assign b_ready = !r_b_valid || i_ready;
    assign a_adv   = !r_a_valid || b_ready;
    assign o_pop   = i_q_valid && a_adv;

    assign rel       = $signed({2'b0, r_pen_x}) + $signed({{11{i_cmd.glyph.bx[7]}},
                                                          i_cmd.glyph.bx});
    assign row_min19 = $signed({{11{r_row_min[7]}}, r_row_min});
    assign pen_adv   = {1'b0, r_pen_x} + {10'b0, i_cmd.glyph.adv};
    assign pen_sat   = pen_adv[17] ? '1 : pen_adv[16:0];
    assign row_wd    = 19'($signed({2'b0, r_row_max}) - row_min19);
    assign line_sum  = {1'b0, r_line_y} + {9'b0, i_line_height};

    always_comb begin
        n_pen_x   = r_pen_x;
        n_line_y  = r_line_y;
        n_row_min = r_row_min;
        n_row_max = r_row_max;
        n_a       = '0;
        unique case (i_cmd.kind)
            CMD_START: begin
                n_pen_x   = '0;
                n_line_y  = '0;
                n_row_min = '0;
                n_row_max = '0;
            end
            CMD_GLYPH: begin
                n_a.x0 = rel + $signed({{3{i_origin_left[15]}}, i_origin_left});
                n_a.y0 = $signed({{2{i_origin_top[15]}}, i_origin_top})
                         + $signed({2'b0, r_line_y})
                         + $signed({10'b0, i_cmd.glyph.ly});
                n_a.w  = {8'b0, i_cmd.glyph.w};
                n_a.h  = i_cmd.glyph.h;
                n_a.ax = i_cmd.glyph.ax;
                n_a.ay = i_cmd.glyph.ay;
                if (rel < row_min19) begin
                    n_row_min = rel[7:0];
                end
                n_row_max = (pen_sat > r_row_max) ? pen_sat : r_row_max;
                n_pen_x   = pen_sat;
            end
            CMD_ROW: begin
                n_a.row   = 1'b1;
                n_a.empty = row_min19 == $signed({2'b0, r_row_max});
                n_a.x0    = row_min19;
                n_a.y0    = $signed({2'b0, r_line_y});
                n_a.w     = (|row_wd[18:16]) ? 16'hffff : row_wd[15:0];
                n_a.h     = i_line_height;
                n_pen_x   = '0;
                n_line_y  = line_sum[16] ? 16'hffff : line_sum[15:0];
                n_row_min = '0;
                n_row_max = '0;
            end
            default: begin
                n_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_pen_x   <= '0;
            r_line_y  <= '0;
            r_row_min <= '0;
            r_row_max <= '0;
        end else begin
            if (a_adv) begin
                r_a_valid <= o_pop && (i_cmd.kind != CMD_START);
            end
            if (o_pop) begin
                r_pen_x   <= n_pen_x;
                r_line_y  <= n_line_y;
                r_row_min <= n_row_min;
                r_row_max <= n_row_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_a <= n_a;
        end
    end

    // clipping against the frame
    assign x0e    = $signed({r_a.x0[18], r_a.x0});
    assign fw20   = $signed({6'b0, i_frame_width});
    assign xs     = x0e[19] ? '0 : x0e;
    assign xe     = x0e + $signed({4'b0, r_a.w});
    assign xc     = (xe > fw20) ? fw20 : xe;
    assign dx     = xc - xs;
    assign skip_x = x0e[19] ? -x0e : '0;

    assign y0e    = $signed({r_a.y0[17], r_a.y0});
    assign fh19   = $signed({5'b0, i_frame_height});
    assign ys     = y0e[18] ? '0 : y0e;
    assign ye     = y0e + $signed({11'b0, r_a.h});
    assign yc     = (ye > fh19) ? fh19 : ye;
    assign dy     = yc - ys;
    assign skip_y = y0e[18] ? -y0e : '0;

    assign org17 = $signed({i_origin_left[15], i_origin_left});
    assign fw17  = $signed({3'b0, i_frame_width});
    assign emit  = (org17 < fw17) && (xs < xc) && (ys < yc);

    always_comb begin
        n_b = '0;
        if (r_a.row) begin
            n_b.kind      = 1'b1;
            n_b.row_empty = r_a.empty;
            if (!r_a.empty) begin
                n_b.pos_x       = r_a.x0[16:0];
                n_b.pos_y       = r_a.y0[16:0];
                n_b.span_width  = r_a.w;
                n_b.span_height = r_a.h;
            end
        end else begin
            n_b.pos_x       = xs[16:0];
            n_b.pos_y       = ys[16:0];
            n_b.span_width  = dx[15:0];
            n_b.span_height = dy[7:0];
            n_b.src_x       = r_a.ax + skip_x[15:0];
            n_b.src_y       = {1'b0, r_a.ay} + skip_y[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid && (r_a.row || emit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready) begin
            r_b <= n_b;
        end
    end

    assign o_valid  = r_b_valid;
    assign o_result = r_b;

endmodule

// File: design/text_glyph_placer.sv
// ----------------------------------------------------------------------------
// text_glyph_placer
// places glyph blit rectangles and row boxes for a stream of character codes
// ----------------------------------------------------------------------------
//
//  port group   dir   transaction
//  -----------  ----  ----------------------------------------------------
//  s_axis_*     in    table load, character, start text or end text
//  m_axis_*     out   glyph blit rectangle or row bounding box
//  apb          in    configuration register write / read
//
// one item is taken every cycle while the command queue has room; an
// item's result passes table read, queue, cursor stage and clip stage with
// result register, the cursor stage being the only loop that carries state
// reset is synchronous and active low; it clears control state, the cursor
// and the registers, the glyph table keeps no reset and is valid once loaded
// a four-entry command queue parts the front from the back, so the input
// keeps flowing while the output is stalled, until the queue fills
//
module text_glyph_placer #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // char_code[7:0], entry_index[14:8], glyph_w[22:15], glyph_h[30:23],
    // bearing_x[38:31], line_offset_y[46:39], advance[54:47],
    // atlas_x[70:55], atlas_y[78:71], zero pad[79]
    input  logic [79:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x[16:0], pos_y[33:17], span_width[49:34], span_height[57:50],
    // src_x[73:58], src_y[82:74], zero pad[87:83]
    output logic [87:0]  m_axis_tdata,
    // result_kind[0], row_empty[1]
    output logic [1:0]   m_axis_tuser,
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tgp_pkg::*;

    // register indexes
    localparam logic [2:0] REG_FIRST_CODE   = 3'd0;
    localparam logic [2:0] REG_END_CODE     = 3'd1;
    localparam logic [2:0] REG_ORIGIN_LEFT  = 3'd2;
    localparam logic [2:0] REG_ORIGIN_TOP   = 3'd3;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd4;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd5;
    localparam logic [2:0] REG_LINE_HEIGHT  = 3'd6;

    logic [7:0]        r_first_code;
    logic [8:0]        r_end_code;
    logic signed [15:0] r_origin_left;
    logic signed [15:0] r_origin_top;
    logic [13:0]       r_frame_width;
    logic [13:0]       r_frame_height;
    logic [7:0]        r_line_height;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    t_item   item;
    t_cmd    front_cmd;
    t_cmd    q_cmd;
    t_result result;
    logic    push;
    logic    q_full;
    logic    q_valid;
    logic    pop;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_code   <= 8'd32;
            r_end_code     <= 9'd127;
            r_origin_left  <= '0;
            r_origin_top   <= '0;
            r_frame_width  <= 14'd640;
            r_frame_height <= 14'd480;
            r_line_height  <= 8'd16;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FIRST_CODE:   r_first_code   <= pwdata[7:0];
                REG_END_CODE:     r_end_code     <= pwdata[8:0];
                REG_ORIGIN_LEFT:  r_origin_left  <= pwdata[15:0];
                REG_ORIGIN_TOP:   r_origin_top   <= pwdata[15:0];
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[13:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[13:0];
                REG_LINE_HEIGHT:  r_line_height  <= pwdata[7:0];
                default: begin
                    // addresses past the register list are ignored
                end
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        case (cfg_idx)
            REG_FIRST_CODE:   prdata = {24'b0, r_first_code};
            REG_END_CODE:     prdata = {23'b0, r_end_code};
            REG_ORIGIN_LEFT:  prdata = {16'b0, r_origin_left};
            REG_ORIGIN_TOP:   prdata = {16'b0, r_origin_top};
            REG_FRAME_WIDTH:  prdata = {18'b0, r_frame_width};
            REG_FRAME_HEIGHT: prdata = {18'b0, r_frame_height};
            REG_LINE_HEIGHT:  prdata = {24'b0, r_line_height};
            default:          prdata = '0;
        endcase
    end

    // ---------------- input unpacking ----------------
    assign item.code         = s_axis_tdata[7:0];
    assign item.idx          = s_axis_tdata[14:8];
    assign item.glyph.w      = s_axis_tdata[22:15];
    assign item.glyph.h      = s_axis_tdata[30:23];
    assign item.glyph.bx     = s_axis_tdata[38:31];
    assign item.glyph.ly     = s_axis_tdata[46:39];
    assign item.glyph.adv    = s_axis_tdata[54:47];
    assign item.glyph.ax     = s_axis_tdata[70:55];
    assign item.glyph.ay     = s_axis_tdata[78:71];

    // front: loads the table, drops characters outside the table, reads glyphs
    tgp_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_opcode     (s_axis_tuser),
        .i_item       (item),
        .i_first_code (r_first_code),
        .i_end_code   (r_end_code),
        .o_push       (push),
        .o_cmd        (front_cmd),
        .i_q_full     (q_full)
    );

    // commands waiting for the back end
    tgp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back: cursor update, placement, clipping, result register
    tgp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_cmd          (q_cmd),
        .o_pop          (pop),
        .i_origin_left  (r_origin_left),
        .i_origin_top   (r_origin_top),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_line_height  (r_line_height),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_result       (result)
    );

    // ---------------- output packing ----------------
    assign m_axis_tdata = {5'b0, result.src_y, result.src_x, result.span_height,
                           result.span_width, result.pos_y, result.pos_x};
    assign m_axis_tuser = {result.row_empty, result.kind};

endmodule
